FILE: design/fbrf_pkg.sv
// shared types, opcodes and constants for the framebuffer rectangle fill engine
package fbrf_pkg;

    localparam int DEF_SCREEN_WIDTH  = 256;
    localparam int DEF_SCREEN_HEIGHT = 256;

    localparam int OP_W     = 3;
    localparam int COORD_W  = 11;
    localparam int CLAMP_W  = COORD_W - 1;
    localparam int COLOR_W  = 8;
    localparam int PIX_W    = 4;
    localparam int STATUS_W = 2;

    localparam logic [COLOR_W-1:0] MAX_COLOR = 8'd15;

    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_PLOT    = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL    = 3'd2;
    localparam logic [OP_W-1:0] OP_OUTLINE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_COLOR  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OFF_SCREEN = 2'd2;

    typedef struct packed {
        logic [CLAMP_W-1:0] x_lo;
        logic [CLAMP_W-1:0] x_hi;
        logic [CLAMP_W-1:0] y_lo;
        logic [CLAMP_W-1:0] y_hi;
    } t_rect;

endpackage

FILE: design/fbrf_mem.sv
// single-port pixel memory with registered read data
module fbrf_mem #(
    parameter int SCREEN_WIDTH  = fbrf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fbrf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_we,
    input  logic [(SCREEN_WIDTH*SCREEN_HEIGHT > 1 ?
                   $clog2(SCREEN_WIDTH*SCREEN_HEIGHT) : 1)-1:0] i_addr,
    input  logic [fbrf_pkg::PIX_W-1:0]  i_wdata,
    output logic [fbrf_pkg::PIX_W-1:0]  o_rdata
);
    import fbrf_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/fbrf_walk.sv
// rectangle walker: one pixel address per cycle, row by row
module fbrf_walk #(
    parameter int SCREEN_WIDTH  = fbrf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fbrf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fbrf_pkg::t_rect i_rect,
    output logic            o_act,
    output logic            o_last,
    output logic [(SCREEN_WIDTH*SCREEN_HEIGHT > 1 ?
                   $clog2(SCREEN_WIDTH*SCREEN_HEIGHT) : 1)-1:0] o_addr
);
    import fbrf_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic               r_busy;
    t_rect              r_rect;
    logic [CLAMP_W-1:0] r_x;
    logic [CLAMP_W-1:0] r_y;
    logic [AW-1:0]      r_base;
    logic               x_end;
    logic               y_end;

    assign x_end  = (r_x == r_rect.x_hi);
    assign y_end  = (r_y == r_rect.y_hi);
    assign o_act  = r_busy;
    assign o_last = r_busy && x_end && y_end;
    assign o_addr = r_base + AW'(r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_last) begin
            r_busy <= 1'b0;
        end
    end

    // row base starts from one multiply, then steps by the screen width
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rect <= i_rect;
            r_x    <= i_rect.x_lo;
            r_y    <= i_rect.y_lo;
            r_base <= AW'(i_rect.y_lo) * AW'(SCREEN_WIDTH);
        end else if (r_busy) begin
            if (x_end) begin
                r_x    <= r_rect.x_lo;
                r_y    <= r_y + CLAMP_W'(1);
                r_base <= r_base + AW'(SCREEN_WIDTH);
            end else begin
                r_x <= r_x + CLAMP_W'(1);
            end
        end
    end

endmodule

FILE: design/framebuffer_rect_fill_engine.sv
// top level: command decode, pass sequencing and result register of the fill engine
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+---------------------------------------------
//  command | i_in_valid  | o_in_ready   | i_operation i_x_a i_y_a i_x_b i_y_b i_color
//  result  | o_out_valid | i_out_ready  | o_status o_read_color
//
// one command at a time; the memory port moves one pixel per cycle
// fill and clear walk one rectangle, outline walks one pass per on-screen edge,
// plot and read walk one pixel; rejected or empty commands skip the walk
// after reset a clearing pass writes zero to all SCREEN_WIDTH*SCREEN_HEIGHT
// pixels before the first command is taken
// a new command is taken while the previous result waits in the output register
module framebuffer_rect_fill_engine #(
    parameter int SCREEN_WIDTH  = fbrf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fbrf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [fbrf_pkg::OP_W-1:0]           i_operation,
    input  logic signed [fbrf_pkg::COORD_W-1:0] i_x_a,
    input  logic signed [fbrf_pkg::COORD_W-1:0] i_y_a,
    input  logic signed [fbrf_pkg::COORD_W-1:0] i_x_b,
    input  logic signed [fbrf_pkg::COORD_W-1:0] i_y_b,
    input  logic [fbrf_pkg::COLOR_W-1:0]        i_color,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [fbrf_pkg::STATUS_W-1:0]       o_status,
    output logic [fbrf_pkg::PIX_W-1:0]          o_read_color
);
    import fbrf_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    localparam logic [CLAMP_W-1:0] X_LAST = CLAMP_W'(SCREEN_WIDTH - 1);
    localparam logic [CLAMP_W-1:0] Y_LAST = CLAMP_W'(SCREEN_HEIGHT - 1);

    typedef enum logic [6:0] {
        S_INIT      = 7'b0000001,
        S_INIT_WAIT = 7'b0000010,
        S_IDLE      = 7'b0000100,
        S_DECODE    = 7'b0001000,
        S_PASS      = 7'b0010000,
        S_WALK      = 7'b0100000,
        S_DONE      = 7'b1000000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [OP_W-1:0]             r_op;
    logic signed [COORD_W-1:0]   r_xa;
    logic signed [COORD_W-1:0]   r_ya;
    logic signed [COORD_W-1:0]   r_xb;
    logic signed [COORD_W-1:0]   r_yb;
    logic [COLOR_W-1:0]          r_color;
    logic [STATUS_W-1:0]         r_status;
    logic [STATUS_W-1:0]         n_status;
    logic [3:0]                  r_mask;
    logic [3:0]                  n_mask;
    logic                        r_out_valid;
    logic [STATUS_W-1:0]         r_out_status;
    logic [PIX_W-1:0]            r_out_color;

    logic signed [COORD_W-1:0]   mn_x;
    logic signed [COORD_W-1:0]   mx_x;
    logic signed [COORD_W-1:0]   mn_y;
    logic signed [COORD_W-1:0]   mx_y;
    logic [CLAMP_W-1:0]          lo_x;
    logic [CLAMP_W-1:0]          hi_x;
    logic [CLAMP_W-1:0]          lo_y;
    logic [CLAMP_W-1:0]          hi_y;
    logic                        empty_x;
    logic                        empty_y;
    logic                        on_xa;
    logic                        on_xb;
    logic                        on_ya;
    logic                        on_yb;
    logic                        bad_color;

    logic [1:0]                  pass_idx;
    t_rect                       pass_rect;
    logic                        walk_start;
    t_rect                       walk_rect;
    logic                        walk_act;
    logic                        walk_last;
    logic [AW-1:0]               walk_addr;
    logic                        mem_we;
    logic [PIX_W-1:0]            mem_wdata;
    logic [PIX_W-1:0]            mem_rdata;
    logic                        out_load;

    function automatic logic on_axis(input logic signed [COORD_W-1:0] v, input int lim);
        on_axis = !v[COORD_W-1] && ({1'b0, v[CLAMP_W-1:0]} < COORD_W'(lim));
    endfunction

    // clamped spans of the corner pair
    always_comb begin
        mn_x    = (r_xa < r_xb) ? r_xa : r_xb;
        mx_x    = (r_xa < r_xb) ? r_xb : r_xa;
        mn_y    = (r_ya < r_yb) ? r_ya : r_yb;
        mx_y    = (r_ya < r_yb) ? r_yb : r_ya;
        lo_x    = mn_x[COORD_W-1] ? '0 : mn_x[CLAMP_W-1:0];
        lo_y    = mn_y[COORD_W-1] ? '0 : mn_y[CLAMP_W-1:0];
        hi_x    = on_axis(mx_x, SCREEN_WIDTH) ? mx_x[CLAMP_W-1:0] : X_LAST;
        hi_y    = on_axis(mx_y, SCREEN_HEIGHT) ? mx_y[CLAMP_W-1:0] : Y_LAST;
        empty_x = mx_x[COORD_W-1] || (!mn_x[COORD_W-1] && !on_axis(mn_x, SCREEN_WIDTH));
        empty_y = mx_y[COORD_W-1] || (!mn_y[COORD_W-1] && !on_axis(mn_y, SCREEN_HEIGHT));
        on_xa   = on_axis(r_xa, SCREEN_WIDTH);
        on_xb   = on_axis(r_xb, SCREEN_WIDTH);
        on_ya   = on_axis(r_ya, SCREEN_HEIGHT);
        on_yb   = on_axis(r_yb, SCREEN_HEIGHT);
        bad_color = (r_color > MAX_COLOR);
    end

    // lowest pending pass and its rectangle
    always_comb begin
        if (r_mask[0]) begin
            pass_idx = 2'd0;
        end else if (r_mask[1]) begin
            pass_idx = 2'd1;
        end else if (r_mask[2]) begin
            pass_idx = 2'd2;
        end else begin
            pass_idx = 2'd3;
        end
        case (pass_idx)
            2'd0: begin
                case (r_op)
                    OP_CLEAR:   pass_rect = '{x_lo: '0, x_hi: X_LAST, y_lo: '0, y_hi: Y_LAST};
                    OP_FILL:    pass_rect = '{x_lo: lo_x, x_hi: hi_x, y_lo: lo_y, y_hi: hi_y};
                    OP_OUTLINE: pass_rect = '{x_lo: r_xa[CLAMP_W-1:0], x_hi: r_xa[CLAMP_W-1:0],
                                              y_lo: lo_y, y_hi: hi_y};
                    default:    pass_rect = '{x_lo: r_xa[CLAMP_W-1:0], x_hi: r_xa[CLAMP_W-1:0],
                                              y_lo: r_ya[CLAMP_W-1:0], y_hi: r_ya[CLAMP_W-1:0]};
                endcase
            end
            2'd1: pass_rect = '{x_lo: r_xb[CLAMP_W-1:0], x_hi: r_xb[CLAMP_W-1:0],
                                y_lo: lo_y, y_hi: hi_y};
            2'd2: pass_rect = '{x_lo: lo_x, x_hi: hi_x,
                                y_lo: r_ya[CLAMP_W-1:0], y_hi: r_ya[CLAMP_W-1:0]};
            default: pass_rect = '{x_lo: lo_x, x_hi: hi_x,
                                   y_lo: r_yb[CLAMP_W-1:0], y_hi: r_yb[CLAMP_W-1:0]};
        endcase
    end

    assign out_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_mask     = r_mask;
        walk_start = 1'b0;
        walk_rect  = pass_rect;
        case (r_state)
            S_INIT: begin
                walk_start = 1'b1;
                walk_rect  = '{x_lo: '0, x_hi: X_LAST, y_lo: '0, y_hi: Y_LAST};
                n_state    = S_INIT_WAIT;
            end
            S_INIT_WAIT: begin
                if (walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = STAT_DONE;
                n_mask   = 4'b0000;
                n_state  = S_PASS;
                case (r_op)
                    OP_CLEAR: begin
                        if (bad_color) begin
                            n_status = STAT_BAD_COLOR;
                        end else begin
                            n_mask = 4'b0001;
                        end
                    end
                    OP_PLOT: begin
                        if (!on_xa || !on_ya) begin
                            n_status = STAT_OFF_SCREEN;
                        end else if (bad_color) begin
                            n_status = STAT_BAD_COLOR;
                        end else begin
                            n_mask = 4'b0001;
                        end
                    end
                    OP_FILL: begin
                        if (bad_color) begin
                            n_status = STAT_BAD_COLOR;
                        end else begin
                            n_mask = {3'b000, !empty_x && !empty_y};
                        end
                    end
                    OP_OUTLINE: begin
                        if (bad_color) begin
                            n_status = STAT_BAD_COLOR;
                        end else begin
                            n_mask = {on_yb && !empty_x, on_ya && !empty_x,
                                      on_xb && !empty_y, on_xa && !empty_y};
                        end
                    end
                    OP_READ: begin
                        if (!on_xa || !on_ya) begin
                            n_status = STAT_OFF_SCREEN;
                        end else begin
                            n_mask = 4'b0001;
                        end
                    end
                    default: begin
                        n_mask = 4'b0000;
                    end
                endcase
            end
            S_PASS: begin
                if (r_mask == 4'b0000) begin
                    n_state = S_DONE;
                end else begin
                    walk_start       = 1'b1;
                    n_mask[pass_idx] = 1'b0;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_PASS;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_mask   <= n_mask;
        if (r_state == S_IDLE && i_in_valid) begin
            r_op    <= i_operation;
            r_xa    <= i_x_a;
            r_ya    <= i_y_a;
            r_xb    <= i_x_b;
            r_yb    <= i_y_b;
            r_color <= i_color;
        end
        if (r_state == S_DONE && out_load) begin
            r_out_status <= r_status;
            r_out_color  <= (r_op == OP_READ && r_status == STAT_DONE) ? mem_rdata : '0;
        end
    end

    // pixel writes for drawing passes, a single read for the read command
    assign mem_we    = (r_state == S_INIT_WAIT) || (r_op != OP_READ);
    assign mem_wdata = (r_state == S_INIT_WAIT) ? '0 : r_color[PIX_W-1:0];

    fbrf_walk #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_rect  (walk_rect),
        .o_act   (walk_act),
        .o_last  (walk_last),
        .o_addr  (walk_addr)
    );

    fbrf_mem #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (walk_act),
        .i_we    (mem_we),
        .i_addr  (walk_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_color = r_out_color;

endmodule
